[rtl/core/bmt_pkg.sv]
// Shared types and constants for the bracket message tokenizer.
// Character codes, message kinds, word classes and the decoded record layout.
// No dependencies.
`timescale 1ns / 1ps

package bmt_pkg;

    // Field widths of the stream items
    localparam int DATA_W    = 8;
    localparam int KIND_W    = 3;
    localparam int WC_W      = 6;
    localparam int ARG_W     = 32;
    localparam int ARG_SLOTS = 7;
    localparam int SLOT_W    = 3;

    // Record layout and its byte-padded bus width
    localparam int REC_W     = KIND_W + WC_W + ARG_SLOTS * ARG_W;
    localparam int M_TDATA_W = ((REC_W + 7) / 8) * 8;

    // Framing and separator characters
    localparam logic [DATA_W-1:0] CH_LT    = 8'h3C; // '<'
    localparam logic [DATA_W-1:0] CH_GT    = 8'h3E; // '>'
    localparam logic [DATA_W-1:0] CH_SP    = 8'h20; // ' '
    localparam logic [DATA_W-1:0] CH_BAR   = 8'h7C; // '|'
    localparam logic [DATA_W-1:0] CH_MINUS = 8'h2D; // '-'
    localparam logic [DATA_W-1:0] CH_DOT   = 8'h2E; // '.'
    localparam logic [DATA_W-1:0] CH_0     = 8'h30;
    localparam logic [DATA_W-1:0] CH_9     = 8'h39;
    localparam logic [DATA_W-1:0] CH_UA    = 8'h41;
    localparam logic [DATA_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [DATA_W-1:0] CH_LA    = 8'h61;
    localparam logic [DATA_W-1:0] CH_LZ    = 8'h7A;

    // Message selector letters
    localparam logic [DATA_W-1:0] CH_CMD_P = 8'h70; // 'p' power
    localparam logic [DATA_W-1:0] CH_CMD_T = 8'h54; // 'T' throttle
    localparam logic [DATA_W-1:0] CH_CMD_R = 8'h72; // 'r' CV read
    localparam logic [DATA_W-1:0] CH_CMD_F = 8'h46; // 'F' function
    localparam logic [DATA_W-1:0] CH_CMD_A = 8'h61; // 'a' current
    localparam logic [DATA_W-1:0] CH_CMD_V = 8'h56; // 'V' session
    localparam logic [DATA_W-1:0] CH_CMD_Y = 8'h79; // 'y' point
    localparam logic [DATA_W-1:0] CH_CMD_X = 8'h78; // 'x' signal

    // Message kinds
    localparam logic [KIND_W-1:0] KIND_POWER    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_THROTTLE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CV_READ  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FUNCTION = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CURRENT  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SESSION  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_POINT    = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SIGNAL   = 3'd7;

    // Class of the characters in the word being built
    localparam logic [1:0] CLS_NONE = 2'd0;
    localparam logic [1:0] CLS_LET  = 2'd1;
    localparam logic [1:0] CLS_NUM  = 2'd2;

    // Decoded record, kind in the lowest bits
    typedef struct packed {
        logic [ARG_SLOTS-1:0][ARG_W-1:0] args;
        logic [WC_W-1:0]                 word_count;
        logic [KIND_W-1:0]               kind;
    } t_rec;

endpackage

[rtl/core/bmt_parse.sv]
// Tokenizer state and frame decode for the bracket message tokenizer.
// Updates word state once per accepted byte and decodes the frame at '>'.
// Depends on bmt_pkg.
`timescale 1ns / 1ps

module bmt_parse import bmt_pkg::*; #(
    parameter int MAX_WORDS = 40,
    parameter int MAX_CHARS = 40
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [DATA_W-1:0] i_byte,
    input  logic              i_buf_start,
    input  logic              i_power,
    output logic              o_res_valid,
    output t_rec              o_rec
);

    localparam int WW = $clog2(MAX_WORDS + 2);
    localparam int CW = $clog2(MAX_CHARS + 1);

    logic                 r_in_frame, n_in_frame;
    logic [WW-1:0]        r_word_idx, n_word_idx;
    logic [CW-1:0]        r_char_cnt, n_char_cnt;
    logic [1:0]           r_class, n_class;
    logic [DATA_W-1:0]    r_cmd_letter, n_cmd_letter;
    logic                 r_cmd_single, n_cmd_single;
    logic [ARG_W-1:0]     r_arg [ARG_SLOTS];
    logic [ARG_W-1:0]     n_arg [ARG_SLOTS];
    logic                 r_neg, n_neg;
    logic                 r_stop, n_stop;
    logic [ARG_W-1:0]     r_session, n_session;

    // State after an optional buffer restart
    logic                 f_in;
    logic [WW-1:0]        f_wi;
    logic [CW-1:0]        f_cc;
    logic [1:0]           f_cls;
    logic                 f_neg, f_stop;

    logic is_letter, is_digit, is_num;
    logic do_open, do_let, do_num, do_gt, do_sep, do_split;
    logic [WW-1:0] wi_inc;
    logic [WW-1:0] wc;
    logic          dec_hit;
    logic [KIND_W-1:0] dec_kind;

    // Restart tokenizer state on a new receive buffer
    always_comb begin
        f_in   = i_buf_start ? 1'b0 : r_in_frame;
        f_wi   = i_buf_start ? '0 : r_word_idx;
        f_cc   = i_buf_start ? '0 : r_char_cnt;
        f_cls  = i_buf_start ? CLS_NONE : r_class;
        f_neg  = i_buf_start ? 1'b0 : r_neg;
        f_stop = i_buf_start ? 1'b0 : r_stop;
    end

    // Classify the byte
    always_comb begin
        is_letter = i_byte inside {[CH_LA:CH_LZ], [CH_UA:CH_UZ]};
        is_digit  = i_byte inside {[CH_0:CH_9]};
        is_num    = is_digit || (i_byte inside {CH_MINUS, CH_DOT});
        do_open   = (i_byte == CH_LT) && !f_in;
        do_let    = f_in && is_letter;
        do_num    = f_in && is_num;
        do_gt     = f_in && (i_byte == CH_GT);
        do_sep    = f_in && (f_cc != '0) && ((i_byte == CH_SP) || (i_byte == CH_BAR));
        do_split  = (do_let && (f_cls == CLS_NUM) && (f_cc != '0))
                 || (do_num && (f_cls == CLS_LET) && (f_cc != '0))
                 || do_sep;
        wi_inc    = f_wi + WW'(1);
    end

    // Decode the finished frame
    always_comb begin
        wc       = f_wi + ((f_cc != '0) ? WW'(1) : WW'(0));
        dec_hit  = 1'b0;
        dec_kind = KIND_POWER;
        case (r_cmd_letter)
            CH_CMD_P: begin
                dec_hit  = (wc == WW'(2)) || (wc == WW'(3));
                dec_kind = KIND_POWER;
            end
            CH_CMD_T: begin
                dec_hit  = (wc == WW'(4));
                dec_kind = KIND_THROTTLE;
            end
            CH_CMD_R: begin
                dec_hit  = (wc == WW'(5)) && (r_arg[0] == r_session);
                dec_kind = KIND_CV_READ;
            end
            CH_CMD_F: begin
                dec_hit  = (wc == WW'(4));
                dec_kind = KIND_FUNCTION;
            end
            CH_CMD_A: begin
                dec_hit  = (wc == WW'(2)) && i_power;
                dec_kind = KIND_CURRENT;
            end
            CH_CMD_V: begin
                dec_hit  = (wc == WW'(2)) || (wc == WW'(8));
                dec_kind = KIND_SESSION;
            end
            CH_CMD_Y: begin
                dec_hit  = (wc == WW'(4));
                dec_kind = KIND_POINT;
            end
            CH_CMD_X: begin
                dec_hit  = (wc == WW'(4));
                dec_kind = KIND_SIGNAL;
            end
            default: begin
                dec_hit  = 1'b0;
                dec_kind = KIND_POWER;
            end
        endcase
        dec_hit = dec_hit && r_cmd_single;
    end

    // Build the record; absent words read as zero
    always_comb begin
        o_rec.kind       = dec_kind;
        o_rec.word_count = WC_W'(wc);
        for (int k = 0; k < ARG_SLOTS; k++) begin
            o_rec.args[k] = (WW'(k + 1) < wc) ? r_arg[k] : '0;
        end
    end

    assign o_res_valid = i_valid && do_gt && dec_hit;

    // Next tokenizer state
    always_comb begin
        logic [CW-1:0]    pos;
        logic             slot_ok;
        logic [SLOT_W-1:0] slot;
        logic [ARG_W-1:0] base;
        logic [ARG_W-1:0] times10;
        logic [ARG_W-1:0] digit;

        n_in_frame   = f_in;
        n_word_idx   = f_wi;
        n_char_cnt   = f_cc;
        n_class      = f_cls;
        n_neg        = f_neg;
        n_stop       = f_stop;
        n_cmd_letter = r_cmd_letter;
        n_cmd_single = r_cmd_single;
        n_session    = r_session;
        for (int k = 0; k < ARG_SLOTS; k++) begin
            n_arg[k] = r_arg[k];
        end

        // Open a frame at '<'
        if (do_open) begin
            n_in_frame   = 1'b1;
            n_word_idx   = '0;
            n_cmd_letter = '0;
            n_cmd_single = 1'b0;
            n_neg        = 1'b0;
            n_stop       = 1'b0;
            n_char_cnt   = '0;
        end

        // Advance to a fresh word
        if (do_split) begin
            n_word_idx = wi_inc;
            for (int k = 0; k < ARG_SLOTS; k++) begin
                if (wi_inc == WW'(k + 1)) begin
                    n_arg[k] = '0;
                end
            end
            n_neg      = 1'b0;
            n_stop     = 1'b0;
            n_char_cnt = '0;
        end

        // Append the character to the current word
        pos     = n_char_cnt;
        slot_ok = (n_word_idx >= WW'(1)) && (n_word_idx <= WW'(ARG_SLOTS));
        slot    = SLOT_W'(n_word_idx - WW'(1));
        base    = n_arg[slot];
        times10 = (base << 3) + (base << 1);
        digit   = {{(ARG_W - 4){1'b0}}, i_byte[3:0]};
        if (do_let || do_num) begin
            if (pos < CW'(MAX_CHARS)) begin
                if (n_word_idx == '0) begin
                    if (pos == '0) begin
                        n_cmd_letter = i_byte;
                    end
                    n_cmd_single = (pos == '0);
                end
                if (!n_stop) begin
                    if ((pos == '0) && (i_byte == CH_MINUS)) begin
                        n_neg = 1'b1;
                    end else if (is_digit) begin
                        if (slot_ok) begin
                            n_arg[slot] = n_neg ? (times10 - digit) : (times10 + digit);
                        end
                    end else begin
                        n_stop = 1'b1;
                    end
                end
                n_char_cnt = pos + CW'(1);
            end
            n_class = do_let ? CLS_LET : CLS_NUM;
        end

        // Close the frame at '>' and take the session from a session message
        if (do_gt) begin
            if (dec_hit && (r_cmd_letter == CH_CMD_V)) begin
                n_session = r_arg[0];
            end
            n_in_frame = 1'b0;
            n_word_idx = '0;
            n_char_cnt = '0;
            n_class    = CLS_NONE;
        end

        // Saturate the word index; the overflowing word restarts empty
        if (n_in_frame && (n_word_idx > WW'(MAX_WORDS))) begin
            n_word_idx = WW'(MAX_WORDS);
            n_char_cnt = '0;
            n_neg      = 1'b0;
            n_stop     = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame   <= 1'b0;
            r_word_idx   <= '0;
            r_char_cnt   <= '0;
            r_class      <= CLS_NONE;
            r_cmd_letter <= '0;
            r_cmd_single <= 1'b0;
            r_neg        <= 1'b0;
            r_stop       <= 1'b0;
            r_session    <= '0;
        end else if (i_valid) begin
            r_in_frame   <= n_in_frame;
            r_word_idx   <= n_word_idx;
            r_char_cnt   <= n_char_cnt;
            r_class      <= n_class;
            r_cmd_letter <= n_cmd_letter;
            r_cmd_single <= n_cmd_single;
            r_neg        <= n_neg;
            r_stop       <= n_stop;
            r_session    <= n_session;
        end
    end

    // Argument values
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            for (int k = 0; k < ARG_SLOTS; k++) begin
                r_arg[k] <= n_arg[k];
            end
        end
    end

endmodule

[rtl/core/bracket_message_tokenizer.sv]
// Top level of the bracket message tokenizer: stream ports, output skid stage.
// Instantiates bmt_parse; depends on bmt_pkg.
//
// Usage:
//   The slave channel takes one received character per request: s_axis_tdata
//   holds the byte, s_axis_tuser set restarts the tokenizer (new receive
//   buffer) before that byte is handled. Frames run from '<' to '>'.
//   The master channel gives one decoded record per recognised frame.
//   i_cfg_we with i_cfg_wdata sets the local power flag; write it only idle.
// Throughput and output path:
//   One byte per cycle while s_axis_tready is high. A frame's record enters
//   the output stage when its '>' is accepted; all per-byte work sits between
//   the tokenizer state registers and the output register.
// Reset:
//   Synchronous, active low; clears frame state, session and power flag,
//   and empties the output stage.
// Stall:
//   A stalled record holds in the output register; a second one goes to the
//   skid register and s_axis_tready drops until the output register drains.
`timescale 1ns / 1ps

module bracket_message_tokenizer import bmt_pkg::*; #(
    parameter int MAX_WORDS = 40,
    parameter int MAX_CHARS = 40
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [DATA_W-1:0]    s_axis_tdata,  // [7:0] data_byte
    input  logic                 s_axis_tuser,  // [0] buffer_start
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [2:0] kind, [8:3] word_count, [40:9] arg1 ... [232:201] arg7, rest zero
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata
);

    logic r_power;
    logic in_acc;
    logic res_valid;
    t_rec res_rec;

    logic r_out_valid, n_out_valid;
    logic r_skid_valid, n_skid_valid;
    t_rec r_out, n_out;
    t_rec r_skid, n_skid;

    assign s_axis_tready = !r_skid_valid;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // Power flag register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power <= 1'b0;
        end else if (i_cfg_we) begin
            r_power <= i_cfg_wdata;
        end
    end

    bmt_parse #(
        .MAX_WORDS (MAX_WORDS),
        .MAX_CHARS (MAX_CHARS)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_acc),
        .i_byte      (s_axis_tdata),
        .i_buf_start (s_axis_tuser),
        .i_power     (r_power),
        .o_res_valid (res_valid),
        .o_rec       (res_rec)
    );

    // Output register with skid: park a record while the output is stalled
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_out_valid && !m_axis_tready) begin
            if (res_valid) begin
                n_skid_valid = 1'b1;
                n_skid       = res_rec;
            end
        end else if (r_skid_valid) begin
            n_out_valid  = 1'b1;
            n_out        = r_skid;
            n_skid_valid = 1'b0;
        end else begin
            n_out_valid = res_valid;
            n_out       = res_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_TDATA_W - REC_W){1'b0}}, r_out};

    // The skid register is only occupied behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while output register empty");

    // The skid register fills only while the output is stalled
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !m_axis_tready))
        else $error("skid register filled without an output stall");

    // A record appears only after an accepted byte
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("record presented without an accepted byte");

endmodule

[test/tb_top.sv]
// Self-checking bench for bracket_message_tokenizer: sends character requests,
// predicts the decoded records in step and checks every record that comes out.
// Depends on bmt_pkg and the bracket_message_tokenizer RTL.
`timescale 1ns / 1ps

module tb_top;
    import bmt_pkg::*;

    localparam int WORD_LIMIT  = 40;
    localparam int CHAR_LIMIT  = 40;
    localparam int HOLD_CYCLES = 80;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [DATA_W-1:0]    s_axis_tdata  = '0;   // [7:0] data_byte
    logic                 s_axis_tuser  = 1'b0; // [0] buffer_start
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [2:0] kind, [8:3] word_count, [40:9] arg1 ... [232:201] arg7, rest zero
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 i_cfg_we      = 1'b0;
    logic                 i_cfg_wdata   = 1'b0;

    // Tokenizer mirror: frame state, session and power flag
    bit          pw_on     = 1'b0;
    bit          fr_open   = 1'b0;
    int unsigned wd_idx    = 0;
    int unsigned ch_cnt    = 0;
    logic [1:0]  ch_cls    = CLS_NONE;
    logic [7:0]  cmd_ch    = '0;
    bit          cmd_one   = 1'b0;
    logic [31:0] arg_val [ARG_SLOTS] = '{default: '0};
    bit          neg_word  = 1'b0;
    bit          stop_word = 1'b0;
    logic [31:0] sess_id   = '0;

    // Records still owed by the block, oldest first
    t_rec pending_records[$];

    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    bit hold_rx = 1'b0;

    int err_count      = 0;
    int bytes_sent     = 0;
    int framed_bytes   = 0;
    int recs_predicted = 0;
    int recs_checked   = 0;
    int kind_hits [8]  = '{default: 0};

    bracket_message_tokenizer #(
        .MAX_WORDS(WORD_LIMIT),
        .MAX_CHARS(CHAR_LIMIT)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    initial begin : clock_gen
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Tokenizer mirror
    // ------------------------------------------------------------------
    function automatic bit letter_char(input logic [7:0] c);
        return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
    endfunction

    function automatic bit digit_like(input logic [7:0] c);
        return (c >= CH_0 && c <= CH_9) || c == CH_MINUS || c == CH_DOT;
    endfunction

    // Open word k: word 0 holds the selector, words 1..7 an argument slot
    function automatic void start_word(input int unsigned k);
        if (k == 0) begin
            cmd_ch  = '0;
            cmd_one = 1'b0;
        end else if (k <= ARG_SLOTS) begin
            arg_val[k-1] = '0;
        end
        neg_word  = 1'b0;
        stop_word = 1'b0;
        ch_cnt    = 0;
    endfunction

    // Add one character to the current word, atoi style for the value
    function automatic void take_char(input logic [7:0] c);
        logic [31:0] tens;
        logic [31:0] digit;
        if (ch_cnt >= CHAR_LIMIT)
            return;
        if (wd_idx == 0) begin
            if (ch_cnt == 0)
                cmd_ch = c;
            cmd_one = (ch_cnt == 0);
        end
        if (!stop_word) begin
            if (ch_cnt == 0 && c == CH_MINUS) begin
                neg_word = 1'b1;
            end else if (c >= CH_0 && c <= CH_9) begin
                if (wd_idx >= 1 && wd_idx <= ARG_SLOTS) begin
                    tens  = arg_val[wd_idx-1] * 32'd10;
                    digit = c - CH_0;
                    arg_val[wd_idx-1] = neg_word ? tens - digit : tens + digit;
                end
            end else begin
                stop_word = 1'b1;
            end
        end
        ch_cnt = ch_cnt + 1;
    endfunction

    // Match the finished frame against the message table
    function automatic bit close_frame(output t_rec rec);
        int unsigned       wc;
        int                i;
        bit                hit;
        logic [KIND_W-1:0] k;
        wc  = wd_idx + ((ch_cnt > 0) ? 1 : 0);
        hit = 1'b0;
        k   = KIND_POWER;
        rec = '0;
        if (cmd_one) begin
            case (cmd_ch)
                CH_CMD_P: begin
                    hit = (wc == 2 || wc == 3);
                    k   = KIND_POWER;
                end
                CH_CMD_T: begin
                    hit = (wc == 4);
                    k   = KIND_THROTTLE;
                end
                CH_CMD_R: begin
                    hit = (wc == 5) && (arg_val[0] == sess_id);
                    k   = KIND_CV_READ;
                end
                CH_CMD_F: begin
                    hit = (wc == 4);
                    k   = KIND_FUNCTION;
                end
                CH_CMD_A: begin
                    hit = (wc == 2) && pw_on;
                    k   = KIND_CURRENT;
                end
                CH_CMD_V: begin
                    hit = (wc == 2 || wc == 8);
                    k   = KIND_SESSION;
                    // a session report replaces the stored session
                    if (hit)
                        sess_id = arg_val[0];
                end
                CH_CMD_Y: begin
                    hit = (wc == 4);
                    k   = KIND_POINT;
                end
                CH_CMD_X: begin
                    hit = (wc == 4);
                    k   = KIND_SIGNAL;
                end
                default: hit = 1'b0;
            endcase
        end
        if (hit) begin
            rec.kind       = k;
            rec.word_count = WC_W'(wc);
            for (i = 1; i <= ARG_SLOTS; i++)
                rec.args[i-1] = (i < wc) ? arg_val[i-1] : '0;
        end
        return hit;
    endfunction

    // Advance the mirror by one character; returns 1 when a record is due
    function automatic bit parse_byte(input logic [7:0] c, input bit restart,
                                      output t_rec rec);
        bit hit;
        hit = 1'b0;
        rec = '0;
        // a new receive buffer drops the partial frame; the session survives
        if (restart) begin
            fr_open   = 1'b0;
            wd_idx    = 0;
            ch_cnt    = 0;
            ch_cls    = CLS_NONE;
            neg_word  = 1'b0;
            stop_word = 1'b0;
        end
        if (c == CH_LT && !fr_open) begin
            fr_open = 1'b1;
            wd_idx  = 0;
            start_word(0);
        end else if (fr_open && letter_char(c)) begin
            if (ch_cls == CLS_NUM && ch_cnt > 0) begin
                wd_idx = wd_idx + 1;
                start_word(wd_idx);
            end
            take_char(c);
            ch_cls = CLS_LET;
        end else if (fr_open && digit_like(c)) begin
            if (ch_cls == CLS_LET && ch_cnt > 0) begin
                wd_idx = wd_idx + 1;
                start_word(wd_idx);
            end
            take_char(c);
            ch_cls = CLS_NUM;
        end else if (fr_open && c == CH_GT) begin
            hit     = close_frame(rec);
            fr_open = 1'b0;
            wd_idx  = 0;
            ch_cnt  = 0;
            ch_cls  = CLS_NONE;
        end else if (fr_open && ch_cnt > 0 && (c == CH_SP || c == CH_BAR)) begin
            wd_idx = wd_idx + 1;
            start_word(wd_idx);
        end
        // clamp the word index; the word at the limit restarts empty
        if (fr_open && wd_idx > WORD_LIMIT) begin
            wd_idx = WORD_LIMIT;
            start_word(WORD_LIMIT);
        end
        return hit;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] c, input bit restart);
        t_rec rec;
        int   gap;
        if (tx_idle && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tuser  <= restart;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
        if ((fr_open && !restart) || c == CH_LT)
            framed_bytes++;
        if (parse_byte(c, restart, rec)) begin
            pending_records.push_back(rec);
            recs_predicted++;
            kind_hits[rec.kind]++;
        end
    endtask

    // Send a string; the byte at restart_at carries buffer_start
    task automatic push_text(input string s, input int restart_at);
        int i;
        for (i = 0; i < s.len(); i++)
            push_byte(s[i], i == restart_at);
    endtask

    // Hold the request side until every owed record has arrived
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_records.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic set_power(input bit on);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= on;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        pw_on = on;
    endtask

    // ------------------------------------------------------------------
    // Random frame content
    // ------------------------------------------------------------------
    function automatic string letter_run(input int n);
        string s;
        int    i;
        s = "";
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 1) != 0)
                s = {s, $sformatf("%c", 8'h61 + $urandom_range(0, 25))};
            else
                s = {s, $sformatf("%c", 8'h41 + $urandom_range(0, 25))};
        end
        return s;
    endfunction

    function automatic string num_text();
        string s;
        int    n;
        int    i;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: s = $sformatf("%0d", int'($urandom_range(0, 2000)) - 1000);
            4: s = $sformatf("%0d", int'($urandom()));
            5: begin
                case ($urandom_range(0, 4))
                    0: s = "2147483647";
                    1: s = "-2147483648";
                    2: s = "4294967295";
                    3: s = "0";
                    default: s = "-0";
                endcase
            end
            6: begin
                // long digit runs wrap and overflow the word buffer
                s = ($urandom_range(0, 1) != 0) ? "-" : "";
                n = $urandom_range(10, 45);
                for (i = 0; i < n; i++)
                    s = {s, $sformatf("%0d", $urandom_range(0, 9))};
            end
            7: begin
                case ($urandom_range(0, 2))
                    0: s = $sformatf("%0d.%0d", $urandom_range(0, 99), $urandom_range(0, 99));
                    1: s = $sformatf("--%0d", $urandom_range(0, 999));
                    default: s = $sformatf("%0d-%0d", $urandom_range(0, 99),
                                           $urandom_range(0, 99));
                endcase
            end
            8: s = letter_run($urandom_range(1, 3));
            default: s = "-";
        endcase
        return s;
    endfunction

    function automatic string gap_text();
        string s;
        case ($urandom_range(0, 5))
            0, 1: s = " ";
            2: s = "|";
            3: s = "  ";
            4: s = " | ";
            default: s = "||";
        endcase
        return s;
    endfunction

    // Mostly well-formed frames; a few have a wrong word count or selector
    function automatic string rand_frame();
        logic [7:0] sel;
        int         pick;
        int         words;
        int         w;
        string      s;
        string      arg;
        pick = $urandom_range(0, 7);
        case (pick)
            0: begin
                sel   = CH_CMD_P;
                words = $urandom_range(2, 3);
            end
            1: begin
                sel   = CH_CMD_T;
                words = 4;
            end
            2: begin
                sel   = CH_CMD_R;
                words = 5;
            end
            3: begin
                sel   = CH_CMD_F;
                words = 4;
            end
            4: begin
                sel   = CH_CMD_A;
                words = 2;
            end
            5: begin
                sel   = CH_CMD_V;
                words = ($urandom_range(0, 1) != 0) ? 8 : 2;
            end
            6: begin
                sel   = CH_CMD_Y;
                words = 4;
            end
            default: begin
                sel   = CH_CMD_X;
                words = 4;
            end
        endcase
        if ($urandom_range(0, 7) == 0)
            words = $urandom_range(1, 10);
        if ($urandom_range(0, 15) == 0)
            s = {"<", letter_run($urandom_range(1, 2))};
        else
            s = {"<", $sformatf("%c", sel)};
        for (w = 1; w < words; w++) begin
            if (pick == 2 && w == 1 && $urandom_range(0, 3) != 0)
                arg = $sformatf("%0d", $signed(sess_id));
            else
                arg = num_text();
            // now and then glue word 1 to the selector; the class switch splits it
            if (!(w == 1 && $urandom_range(0, 3) == 0))
                s = {s, gap_text()};
            s = {s, arg};
        end
        if ($urandom_range(0, 7) == 0)
            s = {s, gap_text()};
        return {s, ">"};
    endfunction

    // ------------------------------------------------------------------
    // Record side: pacing and checking
    // ------------------------------------------------------------------
    initial begin : rx_pacing
        int stall;
        forever begin
            @(posedge i_clk);
            if (hold_rx) begin
                // hold off long enough for the block to fill and stall requests
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_rx = 1'b0;
            end else if (rx_idle && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                stall = $urandom_range(1, 4);
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    function automatic void log_mismatch(input string what, input logic [31:0] want,
                                         input logic [31:0] got);
        err_count++;
        if (err_count <= 10)
            $display("mismatch at %0t ns: %s expected %0d (0x%08h) got %0d (0x%08h)",
                     $time, what, $signed(want), want, $signed(got), got);
    endfunction

    always @(posedge i_clk) begin : record_check
        t_rec want;
        t_rec got;
        int   k;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[REC_W-1:0];
            if (pending_records.size() == 0) begin
                log_mismatch("record with nothing owed, kind", '0, 32'(got.kind));
            end else begin
                want = pending_records.pop_front();
                recs_checked++;
                if (got.kind != want.kind)
                    log_mismatch("kind", 32'(want.kind), 32'(got.kind));
                if (got.word_count != want.word_count)
                    log_mismatch("word_count", 32'(want.word_count), 32'(got.word_count));
                for (k = 0; k < ARG_SLOTS; k++) begin
                    if (got.args[k] != want.args[k])
                        log_mismatch($sformatf("arg%0d", k + 1), want.args[k], got.args[k]);
                end
                if (m_axis_tdata[M_TDATA_W-1:REC_W] != '0)
                    log_mismatch("padding", '0, 32'(m_axis_tdata[M_TDATA_W-1:REC_W]));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Every message kind accepted; refused CV read, current, throttle and unknown selectors
    task automatic test_message_kinds();
        push_text("<p 1>", -1);
        push_text("<p|0|MAIN>", -1);
        push_text("<T 3 -126 1>", -1);
        push_text("<r 0 8 255 1>", -1);
        push_text("<V 1234>", -1);
        push_text("<r 1234 5 29 3>", -1);
        push_text("<r 99 5 29 3>", -1);
        push_text("<F 3 0 1>", -1);
        push_text("<a 5>", -1);
        set_power(1'b1);
        push_text("<a 512>", -1);
        push_text("<V 7 1 -1 0 1 1 2>", -1);
        push_text("<r 7 1 2 3>", -1);
        push_text("<y 17 1 0>", -1);
        push_text("<x 4 2 1>", -1);
        push_text("<Tx 1 2 3>", -1);
        push_text("<T 1 2>", -1);
        push_text("<5 1>", -1);
        wait_drained();
    endtask

    // Number limits, word splitting, long words and the word count ceiling
    task automatic test_word_edges();
        string digits;
        string crowd;
        int    i;
        push_text("<y 2147483647 -2147483648 1>", -1);
        push_text("<x 4294967296 99999999999 -1>", -1);
        push_text("<y12 5 0>", -1);
        push_text("<F  3||4 | 5 >", -1);
        push_text("<x 1.5 --7 -0>", -1);
        push_text("<T12ab 3>", -1);
        digits = "";
        for (i = 0; i < 50; i++)
            digits = {digits, $sformatf("%0d", (i * 7) % 10)};
        push_text({"<p ", digits, ">"}, -1);
        push_text({"<p ", letter_run(45), "7>"}, -1);
        crowd = "<p";
        for (i = 0; i < 45; i++)
            crowd = {crowd, " 1"};
        push_text({crowd, "a5 9>"}, -1);
        push_text("<p 3>", -1);
        wait_drained();
    endtask

    // Bytes outside frames, stray bytes inside, and new receive buffers
    task automatic test_restart_and_noise();
        push_text("abc>123 |", -1);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h80, 1'b0);
        push_text("<p #1<!>", -1);
        push_text("<p", -1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_text(" 7>", -1);
        push_text("<T 1 2", -1);
        push_text("3 4>", 0);
        push_text("<p 0>", 0);
        push_text("<T 1 2 <3>", -1);
        wait_drained();
    endtask

    // Records pile up behind a long hold-off while requests keep coming
    task automatic test_output_backpressure();
        int i;
        hold_rx = 1'b1;
        for (i = 0; i < 12; i++) begin
            if (i % 2 != 0)
                push_text("<p 1>", -1);
            else
                push_text("<T 3 4 5>", -1);
        end
        wait_drained();
    endtask

    // Random mix of frames, broken frames and line noise
    task automatic random_burst(input int n_bytes, input int min_recs);
        int    start_bytes;
        int    start_recs;
        int    choice;
        int    cut;
        int    n;
        int    restart_at;
        string f;
        start_bytes = framed_bytes;
        start_recs  = recs_predicted;
        while (framed_bytes - start_bytes < n_bytes || recs_predicted - start_recs < min_recs)
        begin
            choice = $urandom_range(0, 19);
            f      = rand_frame();
            case ($urandom_range(0, 19))
                0, 1: restart_at = 0;
                2: restart_at = $urandom_range(1, f.len() - 1);
                default: restart_at = -1;
            endcase
            if (choice < 14) begin
                push_text(f, restart_at);
            end else if (choice < 16) begin
                // cut the frame short; what follows lands inside it
                cut = $urandom_range(1, f.len() - 1);
                push_text(f.substr(0, cut - 1), restart_at);
            end else if (choice < 18) begin
                // drop one junk byte into the frame
                cut = $urandom_range(1, f.len() - 1);
                push_text({f.substr(0, cut - 1), $sformatf("%c", $urandom_range(1, 255)),
                           f.substr(cut, f.len() - 1)}, restart_at);
            end else begin
                n = $urandom_range(1, 8);
                repeat (n)
                    push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            end
        end
    endtask

    task automatic test_random_traffic();
        set_power(1'b1);
        random_burst(300, 15);
        set_power(1'b0);
        random_burst(300, 15);
        // last stretch runs flat out on both sides
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        set_power(1'b1);
        random_burst(400, 15);
    endtask

    initial begin : run_sequence
        int n;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_power(1'b0);
        test_message_kinds();
        test_word_edges();
        test_restart_and_noise();
        test_output_backpressure();
        test_random_traffic();

        // let the last records out, then a few quiet cycles
        s_axis_tvalid <= 1'b0;
        for (n = 0; n < 5000 && pending_records.size() != 0; n++)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (pending_records.size() != 0) begin
            $display("%0d records never arrived", pending_records.size());
            err_count += pending_records.size();
        end

        $display("sent %0d request bytes (%0d inside frames), checked %0d records",
                 bytes_sent, framed_bytes, recs_checked);
        $display("by kind: power %0d throttle %0d cv %0d function %0d current %0d",
                 kind_hits[0], kind_hits[1], kind_hits[2], kind_hits[3], kind_hits[4]);
        $display("         session %0d point %0d signal %0d, failures %0d",
                 kind_hits[5], kind_hits[6], kind_hits[7], err_count);
        if (err_count == 0) begin
            $display("[bracket_message_tokenizer] OK");
        end else begin
            $display("[bracket_message_tokenizer] ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("run timed out at %0t ns", $time);
        $display("[bracket_message_tokenizer] ERROR");
        $finish;
    end

endmodule
